>>> rtl/lrpt_pkg.sv
// Shared constants, types and codes for the lock record probe table.
package lrpt_pkg;

    // SLOTS is a power of two: mod SLOTS is a wrap at SLOT_W bits
    localparam int SLOTS     = 64;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);

    localparam int TABLE_W   = 8;
    localparam int TUPLE_W   = 32;
    localparam int ROW_W     = 24;
    localparam int TAB10_W   = 12;

    // residue unit: tuple mod 10 from a nibble sum and the low bit
    localparam int NIB_N     = TUPLE_W / 4;
    localparam int RED_W     = 4;
    localparam int RED_CNT_W = $clog2(NIB_N + 1);
    localparam int ACC_W     = $clog2(NIB_N * 15 + 1);
    localparam int FOLD_W    = 5;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_SCAN   = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;
    localparam logic [2:0] ST_HELD      = 3'd6;
    localparam logic [2:0] ST_NONE      = 3'd7;

    typedef struct packed {
        logic [TABLE_W-1:0] tab;
        logic [TUPLE_W-1:0] tup;
        logic               kind;
        logic [ROW_W-1:0]   row;
    } lrpt_entry_t;

    localparam int ENTRY_W = $bits(lrpt_entry_t);

    typedef struct packed {
        logic                 start;
        logic [TUPLE_W-1:0]   value;
    } lrpt_red_req_t;

endpackage

>>> rtl/lock_record_probe_table.sv
// Lock record table: open addressing with linear probing over a single-port RAM.
//
// Requests: drive req_type and the key fields with start high; the request is
// taken at a rising edge where start is high and busy is low. Results appear on
// status/out_table/out_row/last for one cycle each, marked by out_valid; last
// flags the final result of a request. The receiver cannot hold results off.
// Clear: one result the cycle after the transfer; busy stays low.
// Insert/query: the home slot is ready once the residue unit is done (tuple mod 10
// from eight nibble additions and a fold; mod SLOTS is a wrap at SLOT_W bits).
// Each occupied slot probed then takes a RAM read and a compare; a match ends
// the request at the compare, an empty slot or a full sweep at the next probe step.
// Release scan: a step per empty slot, a RAM read and a compare per occupied
// slot and a closing step; held entries come out in slot order. busy drops at
// the edge that decides the request, so the next transfer can be taken at the
// following edge. Occupancy is kept in one flop per slot, so clearing needs no
// sweep of the RAM. Reset empties the table.
module lock_record_probe_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     req_type,
    input  logic [lrpt_pkg::TABLE_W-1:0]   table_number,
    input  logic [lrpt_pkg::TUPLE_W-1:0]   tuple_number,
    input  logic                           lock_kind,
    input  logic [lrpt_pkg::ROW_W-1:0]     row_slot,
    output logic                           out_valid,
    output logic [2:0]                     status,
    output logic [lrpt_pkg::TABLE_W-1:0]   out_table,
    output logic [lrpt_pkg::ROW_W-1:0]     out_row,
    output logic                           last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RED0  = 4'd1;
    localparam logic [3:0] S_PROBE = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_SCMP  = 4'd5;

    logic [3:0]                        state_reg, state_next;
    logic [lrpt_pkg::SLOTS-1:0]        occ_reg, occ_next;
    logic [lrpt_pkg::SLOT_W-1:0]       s_reg, s_next;
    logic [lrpt_pkg::CNT_W-1:0]        cnt_reg, cnt_next;

    logic [1:0]                        req_reg, req_next;
    logic [lrpt_pkg::TABLE_W-1:0]      tab_reg, tab_next;
    logic [lrpt_pkg::TUPLE_W-1:0]      tup_reg, tup_next;
    logic                              kind_reg, kind_next;
    logic [lrpt_pkg::ROW_W-1:0]        row_reg, row_next;

    logic                              pend_vld_reg, pend_vld_next;
    logic [lrpt_pkg::TABLE_W-1:0]      pend_tab_reg, pend_tab_next;
    logic [lrpt_pkg::ROW_W-1:0]        pend_row_reg, pend_row_next;

    logic                              out_valid_reg, out_valid_next;
    logic [2:0]                        status_reg, status_next;
    logic [lrpt_pkg::TABLE_W-1:0]      out_table_reg, out_table_next;
    logic [lrpt_pkg::ROW_W-1:0]        out_row_reg, out_row_next;
    logic                              last_reg, last_next;

    lrpt_pkg::lrpt_red_req_t           red_req;
    logic                              red_done;
    logic [lrpt_pkg::RED_W-1:0]        red_res;

    logic                              ram_we;
    logic                              ram_re;
    logic [lrpt_pkg::SLOT_W-1:0]       ram_addr;
    lrpt_pkg::lrpt_entry_t             ram_wdata;
    logic [lrpt_pkg::ENTRY_W-1:0]      ram_rdata;
    lrpt_pkg::lrpt_entry_t             rd_entry;

    logic                              accept;
    logic [lrpt_pkg::TAB10_W-1:0]      tab10;
    logic [lrpt_pkg::SLOT_W-1:0]       s_inc;
    logic [lrpt_pkg::SLOT_W-1:0]       scan_idx;
    logic                              key_hit;

    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);
    assign tab10    = {1'b0, tab_reg, 3'b000} + {3'b000, tab_reg, 1'b0};
    assign s_inc    = (s_reg == lrpt_pkg::SLOT_W'(lrpt_pkg::SLOTS - 1))
                      ? '0 : (s_reg + lrpt_pkg::SLOT_W'(1));
    assign scan_idx = cnt_reg[lrpt_pkg::SLOT_W-1:0];
    assign rd_entry = lrpt_pkg::lrpt_entry_t'(ram_rdata);
    assign key_hit  = (rd_entry.tab == tab_reg) && (rd_entry.tup == tup_reg);

    lrpt_modred u_modred (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (red_req),
        .done  (red_done),
        .res   (red_res)
    );

    lrpt_ram #(
        .WIDTH (lrpt_pkg::ENTRY_W),
        .DEPTH (lrpt_pkg::SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        s_next         = s_reg;
        cnt_next       = cnt_reg;
        req_next       = req_reg;
        tab_next       = tab_reg;
        tup_next       = tup_reg;
        kind_next      = kind_reg;
        row_next       = row_reg;
        pend_vld_next  = pend_vld_reg;
        pend_tab_next  = pend_tab_reg;
        pend_row_next  = pend_row_reg;

        out_valid_next = 1'b0;
        status_next    = status_reg;
        out_table_next = out_table_reg;
        out_row_next   = out_row_reg;
        last_next      = last_reg;

        red_req.start  = 1'b0;
        red_req.value  = tuple_number;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = s_reg;
        ram_wdata = '{tab: tab_reg, tup: tup_reg, kind: kind_reg, row: row_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next  = req_type;
                    tab_next  = table_number;
                    tup_next  = tuple_number;
                    kind_next = lock_kind;
                    row_next  = row_slot;
                    case (req_type)
                        lrpt_pkg::REQ_CLEAR:
                        begin
                            occ_next       = '0;
                            out_valid_next = 1'b1;
                            status_next    = lrpt_pkg::ST_CLEARED;
                            out_table_next = '0;
                            out_row_next   = '0;
                            last_next      = 1'b1;
                        end
                        lrpt_pkg::REQ_SCAN:
                        begin
                            cnt_next      = '0;
                            pend_vld_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                        default:
                        begin
                            red_req.start = 1'b1;
                            state_next    = S_RED0;
                        end
                    endcase
                end
            end

            S_RED0:
            begin
                // both mod SLOTS steps are a wrap at SLOT_W bits
                if (red_done)
                begin
                    s_next     = lrpt_pkg::SLOT_W'(tab10) + lrpt_pkg::SLOT_W'(red_res);
                    cnt_next   = '0;
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                if (cnt_reg == lrpt_pkg::CNT_W'(lrpt_pkg::SLOTS))
                begin
                    out_valid_next = 1'b1;
                    status_next    = (req_reg == lrpt_pkg::REQ_INSERT)
                                     ? lrpt_pkg::ST_FULL : lrpt_pkg::ST_NOT_FOUND;
                    out_table_next = '0;
                    out_row_next   = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (!occ_reg[s_reg])
                begin
                    out_valid_next = 1'b1;
                    out_table_next = '0;
                    out_row_next   = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                    if (req_reg == lrpt_pkg::REQ_INSERT)
                    begin
                        ram_we          = 1'b1;
                        occ_next[s_reg] = (tup_reg != '0);
                        status_next     = lrpt_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        status_next = lrpt_pkg::ST_NOT_FOUND;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (req_reg == lrpt_pkg::REQ_INSERT && key_hit)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lrpt_pkg::ST_DUPLICATE;
                    out_table_next = '0;
                    out_row_next   = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (req_reg == lrpt_pkg::REQ_QUERY && key_hit &&
                         rd_entry.kind == kind_reg)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lrpt_pkg::ST_FOUND;
                    out_table_next = '0;
                    out_row_next   = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    s_next     = s_inc;
                    cnt_next   = cnt_reg + lrpt_pkg::CNT_W'(1);
                    state_next = S_PROBE;
                end
            end

            S_SCAN:
            begin
                ram_addr = scan_idx;
                if (cnt_reg == lrpt_pkg::CNT_W'(lrpt_pkg::SLOTS))
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                    if (pend_vld_reg)
                    begin
                        status_next    = lrpt_pkg::ST_HELD;
                        out_table_next = pend_tab_reg;
                        out_row_next   = pend_row_reg;
                    end
                    else
                    begin
                        status_next    = lrpt_pkg::ST_NONE;
                        out_table_next = '0;
                        out_row_next   = '0;
                    end
                    pend_vld_next = 1'b0;
                end
                else if (occ_reg[scan_idx])
                begin
                    ram_re     = 1'b1;
                    state_next = S_SCMP;
                end
                else
                begin
                    cnt_next = cnt_reg + lrpt_pkg::CNT_W'(1);
                end
            end

            S_SCMP:
            begin
                // the held entry is sent only once a later one shows it is not last
                if (pend_vld_reg)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lrpt_pkg::ST_HELD;
                    out_table_next = pend_tab_reg;
                    out_row_next   = pend_row_reg;
                    last_next      = 1'b0;
                end
                pend_vld_next = 1'b1;
                pend_tab_next = rd_entry.tab;
                pend_row_next = rd_entry.row;
                cnt_next      = cnt_reg + lrpt_pkg::CNT_W'(1);
                state_next    = S_SCAN;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        req_reg       <= req_next;
        tab_reg       <= tab_next;
        tup_reg       <= tup_next;
        kind_reg      <= kind_next;
        row_reg       <= row_next;
        pend_tab_reg  <= pend_tab_next;
        pend_row_reg  <= pend_row_next;
        status_reg    <= status_next;
        out_table_reg <= out_table_next;
        out_row_reg   <= out_row_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_table = out_table_reg;
    assign out_row   = out_row_reg;
    assign last      = last_reg;

    a_red_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        red_done |-> (state_reg == S_RED0))
        else $error("residue unit finished outside the home slot phase");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP || state_reg == S_SCMP) |-> $past(ram_re))
        else $error("compare without a RAM read the cycle before");

    a_write_empty_only: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (!occ_reg[s_reg] && req_reg == lrpt_pkg::REQ_INSERT))
        else $error("RAM write to an occupied slot");

    a_not_last_is_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (status_reg == lrpt_pkg::ST_HELD))
        else $error("non-final result that is not a held entry");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (cnt_reg <= lrpt_pkg::CNT_W'(lrpt_pkg::SLOTS)))
        else $error("probe count ran past the table size");

endmodule

>>> rtl/lrpt_ram.sv
// Generic single-port RAM with registered read.
module lrpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lrpt_modred.sv
// Residue unit: tuple mod 10 from a nibble sum (mod 5) and the low bit (mod 2).
module lrpt_modred (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lrpt_pkg::lrpt_red_req_t      req,
    output logic                         done,
    output logic [lrpt_pkg::RED_W-1:0]   res
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [lrpt_pkg::RED_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [lrpt_pkg::TUPLE_W-1:0]    sh_reg, sh_next;
    logic [lrpt_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic                            lsb_reg, lsb_next;
    logic [lrpt_pkg::RED_W-1:0]      res_reg, res_next;
    logic [lrpt_pkg::FOLD_W-1:0]     fold;
    logic [lrpt_pkg::FOLD_W-1:0]     rem5;
    logic [lrpt_pkg::RED_W-1:0]      rem10;

    // 16 = 1 mod 5, so a nibble sum keeps the residue mod 5; one nibble added per cycle
    always_comb
    begin
        fold = lrpt_pkg::FOLD_W'(acc_reg[lrpt_pkg::ACC_W-1:4])
               + lrpt_pkg::FOLD_W'(acc_reg[3:0]);
        if (fold >= lrpt_pkg::FOLD_W'(20))
        begin
            rem5 = fold - lrpt_pkg::FOLD_W'(20);
        end
        else if (fold >= lrpt_pkg::FOLD_W'(15))
        begin
            rem5 = fold - lrpt_pkg::FOLD_W'(15);
        end
        else if (fold >= lrpt_pkg::FOLD_W'(10))
        begin
            rem5 = fold - lrpt_pkg::FOLD_W'(10);
        end
        else if (fold >= lrpt_pkg::FOLD_W'(5))
        begin
            rem5 = fold - lrpt_pkg::FOLD_W'(5);
        end
        else
        begin
            rem5 = fold;
        end
        // pick the one of r and r+5 whose parity matches the tuple
        rem10 = (rem5[0] != lsb_reg) ? (lrpt_pkg::RED_W'(rem5) + lrpt_pkg::RED_W'(5))
                                     : lrpt_pkg::RED_W'(rem5);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        lsb_next  = lsb_reg;
        res_next  = res_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = lrpt_pkg::RED_CNT_W'(lrpt_pkg::NIB_N);
            sh_next   = req.value;
            acc_next  = '0;
            lsb_next  = req.value[0];
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                acc_next = acc_reg + lrpt_pkg::ACC_W'(sh_reg[3:0]);
                sh_next  = sh_reg >> 4;
                cnt_next = cnt_reg - lrpt_pkg::RED_CNT_W'(1);
            end
            else
            begin
                res_next  = rem10;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        lsb_reg <= lsb_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

>>> sim/lrpt_checker.sv
// Checker for the lock record table: tracks slot contents, predicts every result and compares.
module lrpt_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic [lrpt_pkg::TABLE_W-1:0] table_number,
    input  logic [lrpt_pkg::TUPLE_W-1:0] tuple_number,
    input  logic                         lock_kind,
    input  logic [lrpt_pkg::ROW_W-1:0]   row_slot,
    input  logic                         out_valid,
    input  logic [2:0]                   status,
    input  logic [lrpt_pkg::TABLE_W-1:0] out_table,
    input  logic [lrpt_pkg::ROW_W-1:0]   out_row,
    input  logic                         last,
    output int                           pending,
    output int                           errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]                   st;
        logic [lrpt_pkg::TABLE_W-1:0] tab;
        logic [lrpt_pkg::ROW_W-1:0]   row;
        logic                         lst;
    } lock_result_t;

    logic [lrpt_pkg::TABLE_W-1:0] held_tab  [lrpt_pkg::SLOTS];
    logic [lrpt_pkg::TUPLE_W-1:0] held_tup  [lrpt_pkg::SLOTS];
    logic                         held_kind [lrpt_pkg::SLOTS];
    logic [lrpt_pkg::ROW_W-1:0]   held_row  [lrpt_pkg::SLOTS];

    lock_result_t due_results[$];
    int           n_err;

    function automatic int home_slot_of(logic [lrpt_pkg::TABLE_W-1:0] tb,
                                        logic [lrpt_pkg::TUPLE_W-1:0] tp);
        int tab10;
        int tup10;
        tab10 = (int'(tb) * 10) % lrpt_pkg::SLOTS;
        tup10 = int'(tp % 32'd10);
        return (tab10 + tup10) % lrpt_pkg::SLOTS;
    endfunction

    task automatic wipe_table();
        for (int i = 0; i < lrpt_pkg::SLOTS; i++)
        begin
            held_tab[i]  = '0;
            held_tup[i]  = '0;
            held_kind[i] = 1'b0;
            held_row[i]  = '0;
        end
    endtask

    task automatic push_result(logic [2:0] st, logic [lrpt_pkg::TABLE_W-1:0] tb,
                               logic [lrpt_pkg::ROW_W-1:0] rw, logic lst);
        lock_result_t r;
        r.st  = st;
        r.tab = tb;
        r.row = rw;
        r.lst = lst;
        due_results.push_back(r);
    endtask

    // works out the results of one accepted request and updates the slot copy
    task automatic apply_request(logic [1:0] rq, logic [lrpt_pkg::TABLE_W-1:0] tb,
                                 logic [lrpt_pkg::TUPLE_W-1:0] tp, logic kd,
                                 logic [lrpt_pkg::ROW_W-1:0] rw);
        int  s;
        int  held;
        bit  done;
        done = 1'b0;
        case (rq)
            lrpt_pkg::REQ_CLEAR:
            begin
                wipe_table();
                push_result(lrpt_pkg::ST_CLEARED, '0, '0, 1'b1);
            end
            lrpt_pkg::REQ_INSERT:
            begin
                s = home_slot_of(tb, tp);
                for (int n = 0; n < lrpt_pkg::SLOTS && !done; n++)
                begin
                    if (held_tup[s] == '0)
                    begin
                        // a zero tuple is written but leaves the slot empty
                        held_tab[s]  = tb;
                        held_tup[s]  = tp;
                        held_kind[s] = kd;
                        held_row[s]  = rw;
                        push_result(lrpt_pkg::ST_INSERTED, '0, '0, 1'b1);
                        done = 1'b1;
                    end
                    else if (held_tab[s] == tb && held_tup[s] == tp)
                    begin
                        push_result(lrpt_pkg::ST_DUPLICATE, '0, '0, 1'b1);
                        done = 1'b1;
                    end
                    s = (s + 1) % lrpt_pkg::SLOTS;
                end
                if (!done)
                    push_result(lrpt_pkg::ST_FULL, '0, '0, 1'b1);
            end
            lrpt_pkg::REQ_QUERY:
            begin
                s = home_slot_of(tb, tp);
                for (int n = 0; n < lrpt_pkg::SLOTS && !done && held_tup[s] != '0; n++)
                begin
                    if (held_tab[s] == tb && held_tup[s] == tp && held_kind[s] == kd)
                        done = 1'b1;
                    s = (s + 1) % lrpt_pkg::SLOTS;
                end
                push_result(done ? lrpt_pkg::ST_FOUND : lrpt_pkg::ST_NOT_FOUND,
                            '0, '0, 1'b1);
            end
            default:
            begin
                held = 0;
                for (int i = 0; i < lrpt_pkg::SLOTS; i++)
                begin
                    if (held_tup[i] != '0)
                    begin
                        push_result(lrpt_pkg::ST_HELD, held_tab[i], held_row[i], 1'b0);
                        held++;
                    end
                end
                if (held == 0)
                    push_result(lrpt_pkg::ST_NONE, '0, '0, 1'b1);
                else
                    due_results[$].lst = 1'b1;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lock_result_t got;
        lock_result_t want;
        if (!rst_n)
        begin
            wipe_table();
            due_results.delete();
            n_err   = 0;
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            // results first: anything from this edge's transfer comes later
            if (out_valid)
            begin
                got = {status, out_table, out_row, last};
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d table=%0d row=%0d last=%0d",
                             $time, status, out_table, out_row, last);
                    n_err++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected status=%0d table=%0d row=%0d last=%0d",
                                 $time, want.st, want.tab, want.row, want.lst);
                        $display("%0t:          actual   status=%0d table=%0d row=%0d last=%0d",
                                 $time, got.st, got.tab, got.row, got.lst);
                        n_err++;
                    end
                end
            end
            if (start && !busy)
                apply_request(req_type, table_number, tuple_number, lock_kind, row_slot);
            pending <= due_results.size();
            errors  <= n_err;
        end
    end

endmodule

>>> sim/testbench.sv
// Testbench top for the lock record table: clock, reset, request stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [1:0]                   req_type;
    logic [lrpt_pkg::TABLE_W-1:0] table_number;
    logic [lrpt_pkg::TUPLE_W-1:0] tuple_number;
    logic                         lock_kind;
    logic [lrpt_pkg::ROW_W-1:0]   row_slot;
    logic                         out_valid;
    logic [2:0]                   status;
    logic [lrpt_pkg::TABLE_W-1:0] out_table;
    logic [lrpt_pkg::ROW_W-1:0]   out_row;
    logic                         last;
    int                           pending;
    int                           errors;

    int                           idle_pct;
    int                           n_sent;

    // keys handed to insert, used to aim duplicates and queries at live entries
    logic [lrpt_pkg::TABLE_W-1:0] key_tab[$];
    logic [lrpt_pkg::TUPLE_W-1:0] key_tup[$];
    logic                         key_kind[$];

    lock_record_probe_table i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .table_number (table_number),
        .tuple_number (tuple_number),
        .lock_kind    (lock_kind),
        .row_slot     (row_slot),
        .out_valid    (out_valid),
        .status       (status),
        .out_table    (out_table),
        .out_row      (out_row),
        .last         (last)
    );

    lrpt_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .table_number (table_number),
        .tuple_number (tuple_number),
        .lock_kind    (lock_kind),
        .row_slot     (row_slot),
        .out_valid    (out_valid),
        .status       (status),
        .out_table    (out_table),
        .out_row      (out_row),
        .last         (last),
        .pending      (pending),
        .errors       (errors)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // one request, returns at the edge where the transfer takes place
    task automatic send_req(logic [1:0] rq, logic [lrpt_pkg::TABLE_W-1:0] tb,
                            logic [lrpt_pkg::TUPLE_W-1:0] tp, logic kd,
                            logic [lrpt_pkg::ROW_W-1:0] rw);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= rq;
        table_number <= tb;
        tuple_number <= tp;
        lock_kind    <= kd;
        row_slot     <= rw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_sent++;
        if (rq == lrpt_pkg::REQ_CLEAR)
        begin
            key_tab.delete();
            key_tup.delete();
            key_kind.delete();
        end
        else if (rq == lrpt_pkg::REQ_INSERT)
        begin
            key_tab.push_back(tb);
            key_tup.push_back(tp);
            key_kind.push_back(kd);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic [lrpt_pkg::TUPLE_W-1:0] pick_tuple();
        return ($urandom_range(2) != 0) ? lrpt_pkg::TUPLE_W'($urandom_range(1, 60))
                                        : lrpt_pkg::TUPLE_W'($urandom);
    endfunction

    task automatic run_episode();
        int                           target;
        int                           inserted;
        int                           op;
        int                           k;
        logic [lrpt_pkg::TABLE_W-1:0] tb;
        logic [lrpt_pkg::TUPLE_W-1:0] tp;
        inserted = 0;
        if ($urandom_range(9) < 8)
            send_req(lrpt_pkg::REQ_CLEAR, lrpt_pkg::TABLE_W'($urandom), $urandom,
                     1'($urandom), lrpt_pkg::ROW_W'($urandom));
        // a quarter of episodes push the table to full and beyond
        target = ($urandom_range(3) == 0) ? $urandom_range(64, 72) : $urandom_range(1, 14);
        while (inserted < target)
        begin
            op = $urandom_range(99);
            if (op < 55)
            begin
                tb = ($urandom_range(3) == 0) ? lrpt_pkg::TABLE_W'($urandom)
                                              : lrpt_pkg::TABLE_W'($urandom_range(7));
                tp = pick_tuple();
                if (tp == '0)
                    tp = 1;
                send_req(lrpt_pkg::REQ_INSERT, tb, tp, 1'($urandom),
                         lrpt_pkg::ROW_W'($urandom));
                inserted++;
            end
            else if (op < 65 && key_tab.size() != 0)
            begin
                k = $urandom_range(key_tab.size() - 1);
                send_req(lrpt_pkg::REQ_INSERT, key_tab[k], key_tup[k], 1'($urandom),
                         lrpt_pkg::ROW_W'($urandom));
            end
            else if (op < 85)
            begin
                if (key_tab.size() != 0 && $urandom_range(3) != 0)
                begin
                    k = $urandom_range(key_tab.size() - 1);
                    send_req(lrpt_pkg::REQ_QUERY, key_tab[k], key_tup[k],
                             key_kind[k] ^ ($urandom_range(3) == 0),
                             lrpt_pkg::ROW_W'($urandom));
                end
                else
                    send_req(lrpt_pkg::REQ_QUERY, lrpt_pkg::TABLE_W'($urandom_range(7)),
                             pick_tuple(), 1'($urandom), lrpt_pkg::ROW_W'($urandom));
            end
            else if (op < 92)
                send_req(lrpt_pkg::REQ_SCAN, lrpt_pkg::TABLE_W'($urandom), $urandom,
                         1'($urandom), lrpt_pkg::ROW_W'($urandom));
            else
            begin
                // noise, zero tuples included
                tp = ($urandom_range(3) == 0) ? '0 : lrpt_pkg::TUPLE_W'($urandom);
                send_req(2'($urandom), lrpt_pkg::TABLE_W'($urandom), tp, 1'($urandom),
                         lrpt_pkg::ROW_W'($urandom));
            end
        end
        send_req(lrpt_pkg::REQ_SCAN, lrpt_pkg::TABLE_W'($urandom), $urandom, 1'($urandom),
                 lrpt_pkg::ROW_W'($urandom));
    endtask

    initial
    begin
        int prev_pct;
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = lrpt_pkg::REQ_CLEAR;
        table_number = '0;
        tuple_number = '0;
        lock_kind    = 1'b0;
        row_slot     = '0;
        idle_pct     = 20;
        n_sent       = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, field extremes, duplicates, kind mismatch, probe chains, wrap
        send_req(lrpt_pkg::REQ_SCAN,   8'd0,   32'd0,         1'b0, 24'd0);
        send_req(lrpt_pkg::REQ_QUERY,  8'd0,   32'd1,         1'b0, 24'd0);
        send_req(lrpt_pkg::REQ_INSERT, 8'd0,   32'd1,         1'b0, 24'd0);
        send_req(lrpt_pkg::REQ_INSERT, 8'd255, 32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF);
        send_req(lrpt_pkg::REQ_INSERT, 8'd0,   32'd1,         1'b1, 24'd123);
        send_req(lrpt_pkg::REQ_QUERY,  8'd0,   32'd1,         1'b0, 24'd0);
        send_req(lrpt_pkg::REQ_QUERY,  8'd0,   32'd1,         1'b1, 24'd0);
        send_req(lrpt_pkg::REQ_QUERY,  8'd255, 32'hFFFF_FFFF, 1'b1, 24'd0);
        send_req(lrpt_pkg::REQ_INSERT, 8'd3,   32'd0,         1'b1, 24'h5A_5A5A);
        send_req(lrpt_pkg::REQ_QUERY,  8'd3,   32'd0,         1'b1, 24'd0);
        send_req(lrpt_pkg::REQ_INSERT, 8'd0,   32'd11,        1'b0, 24'h00_0011);
        send_req(lrpt_pkg::REQ_INSERT, 8'd0,   32'd21,        1'b0, 24'h00_0021);
        send_req(lrpt_pkg::REQ_QUERY,  8'd0,   32'd21,        1'b0, 24'd0);
        send_req(lrpt_pkg::REQ_INSERT, 8'd255, 32'd9,         1'b1, 24'hA5_A5A5);
        send_req(lrpt_pkg::REQ_INSERT, 8'd255, 32'd19,        1'b0, 24'h00_0019);
        send_req(lrpt_pkg::REQ_QUERY,  8'd255, 32'd19,        1'b0, 24'd0);
        send_req(lrpt_pkg::REQ_QUERY,  8'd7,   32'd45,        1'b1, 24'd0);
        send_req(lrpt_pkg::REQ_SCAN,   8'd0,   32'd0,         1'b0, 24'd0);
        send_req(lrpt_pkg::REQ_CLEAR,  8'd255, 32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF);
        send_req(lrpt_pkg::REQ_SCAN,   8'd0,   32'd0,         1'b0, 24'd0);
        send_req(lrpt_pkg::REQ_QUERY,  8'd0,   32'd1,         1'b0, 24'd0);
        drain();

        n_sent   = 0;
        prev_pct = idle_pct;
        while (n_sent < 480)
        begin
            idle_pct = (n_sent < 160) ? 20 : (n_sent < 320) ? 70 : 0;
            if (idle_pct != prev_pct)
                drain();
            prev_pct = idle_pct;
            run_episode();
        end

        drain();
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
rtl/lrpt_pkg.sv
rtl/lrpt_ram.sv
rtl/lrpt_modred.sv
rtl/lock_record_probe_table.sv
sim/lrpt_checker.sv
sim/testbench.sv
